FILE: rtl/sleu_pkg.sv
// Shared types and constants for the string literal unescaper.
// No dependencies; imported by every module of the block.
package sleu_pkg;

  typedef enum logic [2:0] {
    ModeIdle = 3'd0,
    ModeBody = 3'd1,
    ModeEsc  = 3'd2,
    ModeOct  = 3'd3,
    ModeHex0 = 3'd4,
    ModeHex  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    StByte   = 3'd0,
    StClose  = 3'd1,
    StUnterm = 3'd2,
    StBadEsc = 3'd3,
    StNoDig  = 3'd4,
    StNull   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

  // Up to two results leave the front per accepted item, in order.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } push_t;

  localparam logic [4:0] HexNone = 5'd16;

endpackage

FILE: rtl/string_literal_unescaper_top.sv
// Top level of the C string literal unescaper.
// Depends on sleu_pkg, sleu_front, sleu_queue and sleu_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one source byte per item
//   in char_in_i; start_req_i marks the opening quote of a new literal.
//   Output channel (out_valid_o / out_stall_i) carries decoded results:
//   out_byte_o, status_o (byte, closed, unterminated, bad escape, no digits,
//   null char) and last_o on the final result that one input item causes.
//   An input item causes zero, one or two results.
// Timing:
//   With the queue and output register empty, a result is written into the
//   queue when its input item is accepted and is then loaded into the output
//   register. The front takes one item per cycle as long as the result queue
//   has room for two more entries; the single-entry output register drains one
//   result per cycle while the receiver does not stall, so throughput is set by
//   that output port, and an item that yields two results occupies it for both.
// Stall and reset:
//   While the receiver stalls, results pile up in the queue and the input
//   stalls only once fewer than two free entries remain. Reset empties the
//   queue and the output register and returns the decoder to idle, waiting
//   for a start item; bytes before a start produce nothing.
module string_literal_unescaper_top
  import sleu_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic            accept;
  push_t           push;
  logic            pop;
  result_t         head;
  result_t         out_res;
  logic [CntW-1:0] q_count;

  // Hold the input while the queue cannot absorb a two-result item.
  assign in_stall_o = q_count > CntW'(QueueDepth - 2);
  assign accept     = in_valid_i & ~in_stall_o;

  sleu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_in_i   (char_in_i),
    .start_req_i (start_req_i),
    .push_o      (push)
  );

  sleu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  sleu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_count != '0),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign out_byte_o = out_res.data;
  assign status_o   = out_res.status;
  assign last_o     = out_res.last;

  // Queue never overfills.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QueueDepth))
    else $error("result queue overflow");

  // A second result always follows a first one.
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid1 |-> push.valid0)
    else $error("second result pushed without first");

  // A queued result reaches an idle output register in the next cycle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count != '0) && !out_valid_o |=> out_valid_o)
    else $error("output register failed to load");

  // A push of one or two results never meets a queue without room for two.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid0 |-> q_count <= CntW'(QueueDepth - 2))
    else $error("push into full queue");

endmodule

FILE: rtl/sleu_front.sv
// Front end: accepts source bytes, tracks the escape state, builds results.
// Depends on sleu_pkg.
module sleu_front
  import sleu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_in_i,
  input  logic       start_req_i,
  output push_t      push_o
);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChXl    = 8'h78;
  localparam logic [7:0] ChXu    = 8'h58;

  typedef struct packed {
    logic    emit;
    result_t res;
    mode_e   mode;
  } step_t;

  mode_e      mode_q, mode_d;
  logic [7:0] esc_q, esc_d;
  logic [1:0] cnt_q, cnt_d;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = HexNone;
    if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    else if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    return v;
  endfunction

  function automatic result_t mk(input logic [7:0] d, input status_e s);
    result_t r;
    r.data   = d;
    r.status = s;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic step_t body(input logic [7:0] c);
    step_t s;
    s.emit = 1'b1;
    s.mode = ModeBody;
    s.res  = mk(c, StByte);
    if (c == ChQuote) begin
      s.res  = mk(8'h00, StClose);
      s.mode = ModeIdle;
    end else if (c == ChBsl) begin
      s.emit = 1'b0;
      s.mode = ModeEsc;
    end
    return s;
  endfunction

  // Close a numeric escape: a zero value is an error.
  function automatic step_t finish(input logic [7:0] v);
    step_t s;
    s.emit = 1'b1;
    if (v == 8'h00) begin
      s.res  = mk(8'h00, StNull);
      s.mode = ModeIdle;
    end else begin
      s.res  = mk(v, StByte);
      s.mode = ModeBody;
    end
    return s;
  endfunction

  logic [4:0]  dig;
  logic [10:0] oct_nv;
  logic [7:0]  hex_nv;
  step_t       fin, chain;
  logic        v0, v1;
  result_t     r0, r1;

  always_comb begin
    dig    = hex_val(char_in_i);
    oct_nv = {esc_q, 3'b000} + 11'(dig);
    hex_nv = {esc_q[3:0], 4'b0000} + 8'(dig);
    mode_d = mode_q;
    esc_d  = esc_q;
    cnt_d  = cnt_q;
    v0     = 1'b0;
    v1     = 1'b0;
    r0     = mk(8'h00, StByte);
    r1     = mk(8'h00, StByte);
    fin    = finish(8'h00);
    chain  = body(char_in_i);
    if (start_req_i) begin
      if (mode_q != ModeIdle) begin
        v0 = 1'b1;
        r0 = mk(8'h00, StUnterm);
      end
      mode_d = ModeBody;
      esc_d  = 8'h00;
      cnt_d  = 2'd0;
    end else if (mode_q == ModeIdle) begin
      mode_d = ModeIdle;
    end else if (char_in_i == ChNul) begin
      v0     = 1'b1;
      r0     = mk(8'h00, StUnterm);
      mode_d = ModeIdle;
      esc_d  = 8'h00;
      cnt_d  = 2'd0;
    end else begin
      case (mode_q)
        ModeBody: begin
          v0     = chain.emit;
          r0     = chain.res;
          mode_d = chain.mode;
        end
        ModeEsc: begin
          mode_d = ModeBody;
          v0     = 1'b1;
          case (char_in_i)
            ChNl: v0 = 1'b0;
            ChBsl, ChQmark, ChApos, ChQuote: r0 = mk(char_in_i, StByte);
            ChA: r0 = mk(8'd7, StByte);
            ChB: r0 = mk(8'd8, StByte);
            ChF: r0 = mk(8'd12, StByte);
            ChN: r0 = mk(8'd10, StByte);
            ChR: r0 = mk(8'd13, StByte);
            ChT: r0 = mk(8'd9, StByte);
            ChV: r0 = mk(8'd11, StByte);
            ChXl, ChXu: begin
              v0     = 1'b0;
              mode_d = ModeHex0;
            end
            default: begin
              if (char_in_i inside {[8'h30:8'h37]}) begin
                v0     = 1'b0;
                esc_d  = {5'd0, char_in_i[2:0]};
                cnt_d  = 2'd1;
                mode_d = ModeOct;
              end else begin
                r0     = mk(8'h00, StBadEsc);
                mode_d = ModeIdle;
              end
            end
          endcase
        end
        ModeOct: begin
          if (dig < 5'd8 && oct_nv <= 11'd255) begin
            esc_d = oct_nv[7:0];
            cnt_d = cnt_q + 2'd1;
            if (cnt_d == 2'd3) begin
              fin    = finish(oct_nv[7:0]);
              v0     = 1'b1;
              r0     = fin.res;
              mode_d = fin.mode;
              esc_d  = 8'h00;
              cnt_d  = 2'd0;
            end
          end else begin
            fin    = finish(esc_q);
            v0     = 1'b1;
            r0     = fin.res;
            mode_d = fin.mode;
            esc_d  = 8'h00;
            cnt_d  = 2'd0;
            if (fin.mode == ModeBody) begin
              v1     = chain.emit;
              r1     = chain.res;
              mode_d = chain.mode;
            end
          end
        end
        ModeHex0: begin
          if (dig != HexNone) begin
            esc_d  = {4'd0, dig[3:0]};
            cnt_d  = 2'd1;
            mode_d = ModeHex;
          end else begin
            v0     = 1'b1;
            r0     = mk(8'h00, StNoDig);
            mode_d = ModeIdle;
          end
        end
        ModeHex: begin
          fin   = finish((dig != HexNone) ? hex_nv : esc_q);
          v0    = 1'b1;
          r0    = fin.res;
          mode_d = fin.mode;
          esc_d = 8'h00;
          cnt_d = 2'd0;
          if (dig == HexNone && fin.mode == ModeBody) begin
            v1     = chain.emit;
            r1     = chain.res;
            mode_d = chain.mode;
          end
        end
        default: mode_d = ModeIdle;
      endcase
    end
    r0.last = ~v1;
    r1.last = 1'b1;
  end

  assign push_o.valid0 = accept_i & v0;
  assign push_o.valid1 = accept_i & v0 & v1;
  assign push_o.res0   = r0;
  assign push_o.res1   = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      esc_q  <= 8'h00;
      cnt_q  <= 2'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: rtl/sleu_queue.sv
// Result queue between front and back: two writes, one read per cycle.
// Depends on sleu_pkg.
module sleu_queue
  import sleu_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  push_t                      push_i,
  input  logic                       pop_i,
  output result_t                    head_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t             mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0]     cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_nx = inc(wr_q);
    wr_d  = wr_q;
    if (push_i.valid1) wr_d = inc(wr_nx);
    else if (push_i.valid0) wr_d = wr_nx;
    rd_d  = pop_i ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.valid0) + CntW'(push_i.valid1) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) mem_q[wr_q] <= push_i.res0;
    if (push_i.valid1) mem_q[wr_nx] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

FILE: rtl/sleu_back.sv
// Back end: output register that drains the queue toward the receiver.
// Depends on sleu_pkg.
module sleu_back
  import sleu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  result_t head_i,
  output logic    pop_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t out_o
);

  logic    valid_q;
  result_t out_q;

  // Load whenever a result is queued and the register is empty or its item leaves this cycle.
  assign pop_o = avail_i & (~valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= head_i;
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

FILE: tb/string_literal_unescaper_top_test.sv
// Self-checking testbench for the string literal unescaper top level.
// Depends on sleu_pkg and string_literal_unescaper_top; drives both
// valid/stall channels and checks every decoded result in order.
`timescale 1ns / 100ps

module string_literal_unescaper_top_test;
  import sleu_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned LiveItemGoal  = 700;
  localparam int unsigned QuietFrom     = 620;
  localparam int unsigned MaxPrinted    = 40;

  localparam logic [7:0] Bslash  = 8'h5C;
  localparam logic [7:0] Quote   = 8'h22;
  localparam logic [7:0] Newline = 8'h0A;
  localparam logic [7:0] Nul     = 8'h00;
  // Bit 8 of a directed entry marks an opening-delimiter item.
  localparam int unsigned StartMark = 'h100;

  // Shadow decoder plus the queue of results it has predicted.
  class unescape_scoreboard;
    mode_e      mode;
    logic [7:0] escape_value;
    int         digit_count;
    result_t    step_out[$];
    result_t    decoded_q[$];
    int         fail_count;

    function new();
      mode         = ModeIdle;
      escape_value = 8'd0;
      digit_count  = 0;
      fail_count   = 0;
    endfunction

    task report_mismatch(string what);
      fail_count++;
      if (fail_count <= MaxPrinted) begin
        $display("mismatch: %s", what);
      end
    endtask

    function void emit(logic [7:0] data, status_e st);
      result_t r;
      r.data   = data;
      r.status = st;
      r.last   = 1'b0;
      step_out.push_back(r);
    endfunction

    function int hex_digit(logic [7:0] ch);
      if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
      if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
      if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
      return 16;
    endfunction

    // Finish a numeric escape; returns 1 while the literal stays open.
    function bit close_number();
      logic [7:0] v;
      v            = escape_value;
      escape_value = 8'd0;
      digit_count  = 0;
      if (v == 8'd0) begin
        emit(8'd0, StNull);
        mode = ModeIdle;
        return 1'b0;
      end
      emit(v, StByte);
      mode = ModeBody;
      return 1'b1;
    endfunction

    function void body_char(logic [7:0] ch);
      if (ch == Quote) begin
        emit(8'd0, StClose);
        mode = ModeIdle;
      end else if (ch == Bslash) begin
        mode = ModeEsc;
      end else begin
        emit(ch, StByte);
      end
    endfunction

    function void escape_char(logic [7:0] ch);
      mode = ModeBody;
      case (ch)
        Newline: ;
        "\\", "?", "'", "\"": emit(ch, StByte);
        "a": emit(8'd7, StByte);
        "b": emit(8'd8, StByte);
        "f": emit(8'd12, StByte);
        "n": emit(8'd10, StByte);
        "r": emit(8'd13, StByte);
        "t": emit(8'd9, StByte);
        "v": emit(8'd11, StByte);
        "x", "X": mode = ModeHex0;
        default: begin
          if (ch >= "0" && ch <= "7") begin
            escape_value = ch - 8'("0");
            digit_count  = 1;
            mode         = ModeOct;
          end else begin
            emit(8'd0, StBadEsc);
            mode = ModeIdle;
          end
        end
      endcase
    endfunction

    // Predict the results of one accepted item; returns 1 unless it is ignored.
    function bit decode_char(logic [7:0] ch, logic start);
      int dig;
      int nxt;
      bit live;
      step_out.delete();
      live = start || (mode != ModeIdle);
      if (start) begin
        if (mode != ModeIdle) emit(8'd0, StUnterm);
        mode         = ModeBody;
        escape_value = 8'd0;
        digit_count  = 0;
      end else if (mode == ModeIdle) begin
        // bytes outside a literal are dropped
      end else if (ch == Nul) begin
        emit(8'd0, StUnterm);
        mode         = ModeIdle;
        escape_value = 8'd0;
        digit_count  = 0;
      end else begin
        case (mode)
          ModeBody: body_char(ch);
          ModeEsc:  escape_char(ch);
          ModeOct: begin
            dig = hex_digit(ch);
            nxt = int'(escape_value) * 8 + dig;
            if (dig < 8 && nxt <= 255) begin
              escape_value = nxt[7:0];
              digit_count++;
              if (digit_count >= 3) void'(close_number());
            end else if (close_number()) begin
              body_char(ch);
            end
          end
          ModeHex0: begin
            dig = hex_digit(ch);
            if (dig < 16) begin
              escape_value = dig[7:0];
              digit_count  = 1;
              mode         = ModeHex;
            end else begin
              emit(8'd0, StNoDig);
              mode = ModeIdle;
            end
          end
          default: begin
            dig = hex_digit(ch);
            if (dig < 16) begin
              nxt          = int'(escape_value) * 16 + dig;
              escape_value = nxt[7:0];
              digit_count  = 2;
              void'(close_number());
            end else if (close_number()) begin
              body_char(ch);
            end
          end
        endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) decoded_q.push_back(step_out[i]);
      return live;
    endfunction

    task check_decoded(logic [7:0] data, logic [2:0] st, logic last);
      result_t want;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h status %0d last %0b",
                                  data, st, last));
        return;
      end
      want = decoded_q.pop_front();
      if (data !== want.data) begin
        report_mismatch($sformatf("out_byte %h, want %h", data, want.data));
      end
      if (st !== want.status) begin
        report_mismatch($sformatf("status %0d, want %s", st, want.status.name()));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    endtask
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] char_in   = 8'd0;
  logic       start_req = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  unescape_scoreboard sb;
  bit         idle_on    = 1'b1;
  int         live_count = 0;

  always #5 clk = ~clk;

  string_literal_unescaper_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .char_in_i   (char_in),
    .start_req_i (start_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .status_o    (status),
    .last_o      (last)
  );

  // Offer one item, optionally after an idle burst, and hold it until accepted.
  // Acceptance is judged on the values seen at the edge, before any update.
  task automatic push_char(logic [7:0] ch, logic start);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_in   <= ch;
    start_req <= start;
    do @(posedge clk); while (in_stall);
    if (sb.decode_char(ch, start)) live_count++;
  endtask

  // Any byte that is neither a quote nor a backslash, never NUL.
  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (ch == Quote || ch == Bslash);
    return ch;
  endfunction

  function automatic logic [7:0] simple_escape();
    logic [7:0] picks [12];
    picks = '{Newline, "\\", "?", "'", "\"", "a", "b", "f", "n", "r", "t", "v"};
    return picks[$urandom_range(0, 11)];
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // One literal: opening item, a run of random parts, then mostly a close.
  task automatic send_literal();
    int n_parts;
    int kind;
    int ndig;
    int tail;
    push_char(8'($urandom), 1'b1);
    n_parts = $urandom_range(0, 10);
    for (int k = 0; k < n_parts; k++) begin
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        push_char(plain_char(), 1'b0);
      end else if (kind < 11) begin
        push_char(Bslash, 1'b0);
        push_char(simple_escape(), 1'b0);
      end else if (kind < 14) begin
        // octal run; a following digit may or may not extend it
        push_char(Bslash, 1'b0);
        ndig = $urandom_range(1, 3);
        repeat (ndig) push_char(8'("0") + 8'($urandom_range(0, 7)), 1'b0);
      end else if (kind < 17) begin
        push_char(Bslash, 1'b0);
        push_char($urandom_range(0, 1) ? 8'("x") : 8'("X"), 1'b0);
        ndig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
        repeat (ndig) push_char(hex_char(), 1'b0);
      end else if (kind == 17) begin
        push_char(Bslash, 1'b0);
        push_char(8'($urandom), 1'b0);
      end else if (kind == 18) begin
        push_char(8'($urandom), 1'b0);
      end else begin
        push_char(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    tail = $urandom_range(0, 9);
    if (tail < 8) push_char(Quote, 1'b0);
    else if (tail == 8) push_char(Nul, 1'b0);
  endtask

  // Receiver: random stall bursts while idling is on.
  initial begin : receiver_stall
    int hold;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        hold = $urandom_range(1, 8);
        repeat (hold - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every result the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_decoded(out_byte, status, last);
    end
  end

  // End the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned directed [$];
    sb = new();
    // Directed part: extremes, the substitutions, numeric escapes that stop
    // early or run to three digits, and each error path.
    directed = '{
      StartMark + 'hFF,                // opening item carries an ignored byte
      Bslash, Newline,                 // line splice, no result
      Bslash, "3", "7", "7",           // largest octal value, three digits
      Bslash, "4", "0", "0",           // stop before passing 255, then body '0'
      Bslash, "x", "4", 'hFF,          // hex ended by a byte, two results
      Bslash, "x", "g",                // hex with no digits
      "A",                             // byte while idle, dropped
      StartMark + "q", Bslash, "0", Quote,  // numeric escape of value zero
      StartMark, "a",
      StartMark, Bslash, "q",          // abandon open literal, then bad escape
      StartMark, Nul,                  // NUL inside a literal
      StartMark, Quote                 // empty literal, clean close
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_char(directed[i][7:0], directed[i][8]);

    // Random part: mostly well-formed literals, some stray noise between them.
    while (live_count < LiveItemGoal) begin
      if (live_count >= QuietFrom) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) push_char(8'($urandom), $urandom_range(0, 7) == 0);
      else send_literal();
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sleu_pkg.sv
rtl/sleu_front.sv
rtl/sleu_queue.sv
rtl/sleu_back.sv
rtl/string_literal_unescaper_top.sv
tb/string_literal_unescaper_top_test.sv
